/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every clock outside reset.
`define VRSI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define VRSI_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

/* rtl/vrsi_pkg.sv */
package vrsi_pkg;

  localparam int SPRITE_BYTES_DEF = 256;

  typedef enum logic [4:0] {
    CMD_CTRL_WR     = 5'd0,
    CMD_MASK_WR     = 5'd1,
    CMD_STATUS_RD   = 5'd2,
    CMD_SPR_ADDR_WR = 5'd3,
    CMD_SPR_DATA_WR = 5'd4,
    CMD_SPR_DATA_RD = 5'd5,
    CMD_SCROLL_WR   = 5'd6,
    CMD_ADDR_WR     = 5'd7,
    CMD_DATA_WR     = 5'd8,
    CMD_DATA_RD     = 5'd9,
    CMD_COARSE_X    = 5'd10,
    CMD_FINE_Y      = 5'd11,
    CMD_COPY_HORIZ  = 5'd12,
    CMD_COPY_VERT   = 5'd13,
    CMD_VBLANK      = 5'd14,
    CMD_PRERENDER   = 5'd15,
    CMD_SPR_ZERO    = 5'd16,
    CMD_SPR_OVF     = 5'd17
  } cmd_t;

  localparam logic [13:0] PALETTE_BASE = 14'h3f00;
  localparam logic [14:0] HORIZ_MASK   = 15'h041f;
  localparam logic [14:0] VERT_MASK    = 15'h7be0;
  localparam logic [4:0]  MASK_RESET   = 5'h18;
  localparam logic [4:0]  LAST_COL     = 5'd31;
  localparam logic [4:0]  LAST_ROW     = 5'd29;
  localparam logic [4:0]  ROW_MAX      = 5'd31;
  localparam logic [14:0] INC_ACROSS   = 15'd1;
  localparam logic [14:0] INC_DOWN     = 15'd32;

  // Sprite memory access requested by the register file for one request.
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [7:0] data;
  } spr_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] vram_addr;
    logic        vram_write;
    logic        irq;
    logic [2:0]  fine_x;
    logic [7:0]  render_flags;
  } res_t;

endpackage

/* rtl/vrsi_regs.sv */
module vrsi_regs
  import vrsi_pkg::*;
#(
  parameter int SPRITE_BYTES = SPRITE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [4:0]                      command,
  input  logic [7:0]                      write_data,
  input  logic [7:0]                      vram_data,
  output res_t                            res,
  output spr_req_t                        spr_req,
  output logic [$clog2(SPRITE_BYTES)-1:0] spr_addr
);

  localparam int SprAw = $clog2(SPRITE_BYTES);

  logic [14:0]      cur_r,    cur_nxt;
  logic [14:0]      temp_r,   temp_nxt;
  logic [2:0]       fine_r,   fine_nxt;
  logic             first_r,  first_nxt;
  logic [7:0]       buf_r,    buf_nxt;
  logic [4:0]       ctrl_r,   ctrl_nxt;
  logic [4:0]       mask_r,   mask_nxt;
  logic [2:0]       status_r, status_nxt;
  logic [SprAw-1:0] saddr_r,  saddr_nxt;

  logic [14:0] inc;
  logic        render_on;
  logic [4:0]  row;

  assign inc       = ctrl_r[0] ? INC_DOWN : INC_ACROSS;
  assign render_on = mask_r[3] | mask_r[4];
  assign spr_addr  = saddr_r;

  always_comb begin
    cur_nxt    = cur_r;
    temp_nxt   = temp_r;
    fine_nxt   = fine_r;
    first_nxt  = first_r;
    buf_nxt    = buf_r;
    ctrl_nxt   = ctrl_r;
    mask_nxt   = mask_r;
    status_nxt = status_r;
    saddr_nxt  = saddr_r;
    row        = cur_r[9:5];
    res        = '0;
    spr_req    = '0;
    spr_req.data = write_data;
    res.vram_addr = cur_r;

    case (cmd_t'(command))
      CMD_CTRL_WR: begin
        ctrl_nxt = {write_data[7], write_data[5], write_data[4], write_data[3],
                    write_data[2]};
        temp_nxt[11:10] = write_data[1:0];
      end
      CMD_MASK_WR: begin
        mask_nxt = {write_data[4], write_data[3], ~write_data[2], ~write_data[1],
                    write_data[0]};
      end
      CMD_STATUS_RD: begin
        res.read_data = {status_r, 5'b0};
        status_nxt[2] = 1'b0;
        first_nxt     = 1'b1;
      end
      CMD_SPR_ADDR_WR: begin
        saddr_nxt = write_data[SprAw-1:0];
      end
      CMD_SPR_DATA_WR: begin
        spr_req.wr = 1'b1;
        saddr_nxt  = saddr_r + 1'b1;
      end
      CMD_SPR_DATA_RD: begin
        spr_req.rd = 1'b1;
      end
      CMD_SCROLL_WR: begin
        if (first_r) begin
          temp_nxt[4:0] = write_data[7:3];
          fine_nxt      = write_data[2:0];
          first_nxt     = 1'b0;
        end else begin
          temp_nxt[14:12] = write_data[2:0];
          temp_nxt[9:5]   = write_data[7:3];
          first_nxt       = 1'b1;
        end
      end
      CMD_ADDR_WR: begin
        if (first_r) begin
          temp_nxt[13:8] = write_data[5:0];
          temp_nxt[14]   = 1'b0;
          first_nxt      = 1'b0;
        end else begin
          temp_nxt[7:0] = write_data;
          cur_nxt       = {temp_r[14:8], write_data};
          first_nxt     = 1'b1;
        end
      end
      CMD_DATA_WR: begin
        res.vram_write = 1'b1;
        cur_nxt        = cur_r + inc;
      end
      CMD_DATA_RD: begin
        // palette range bypasses the read buffer
        res.read_data = (cur_r[13:0] >= PALETTE_BASE) ? vram_data : buf_r;
        buf_nxt       = vram_data;
        cur_nxt       = cur_r + inc;
      end
      CMD_COARSE_X: begin
        if (render_on) begin
          if (cur_r[4:0] == LAST_COL) begin
            cur_nxt[4:0] = 5'd0;
            cur_nxt[10]  = ~cur_r[10];
          end else begin
            cur_nxt = cur_r + INC_ACROSS;
          end
        end
      end
      CMD_FINE_Y: begin
        if (render_on) begin
          if (cur_r[14:12] != 3'd7) begin
            cur_nxt[14:12] = cur_r[14:12] + 3'd1;
          end else begin
            cur_nxt[14:12] = 3'd0;
            if (row == LAST_ROW) begin
              cur_nxt[9:5] = 5'd0;
              cur_nxt[11]  = ~cur_r[11];
            end else if (row == ROW_MAX) begin
              cur_nxt[9:5] = 5'd0;
            end else begin
              cur_nxt[9:5] = row + 5'd1;
            end
          end
        end
      end
      CMD_COPY_HORIZ: begin
        if (render_on) begin
          cur_nxt = (cur_r & ~HORIZ_MASK) | (temp_r & HORIZ_MASK);
        end
      end
      CMD_COPY_VERT: begin
        if (render_on) begin
          cur_nxt = (cur_r & ~VERT_MASK) | (temp_r & VERT_MASK);
        end
      end
      CMD_VBLANK: begin
        status_nxt[2] = 1'b1;
        res.irq       = ctrl_r[4];
      end
      CMD_PRERENDER: begin
        status_nxt = 3'b000;
      end
      CMD_SPR_ZERO: begin
        status_nxt[1] = 1'b1;
      end
      CMD_SPR_OVF: begin
        status_nxt[0] = 1'b1;
      end
      default: begin
      end
    endcase

    res.fine_x       = fine_nxt;
    res.render_flags = {ctrl_nxt[1], ctrl_nxt[2], ctrl_nxt[3], mask_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      temp_r   <= '0;
      fine_r   <= '0;
      first_r  <= 1'b1;
      buf_r    <= '0;
      ctrl_r   <= '0;
      mask_r   <= MASK_RESET;
      status_r <= '0;
      saddr_r  <= '0;
    end else if (en) begin
      cur_r    <= cur_nxt;
      temp_r   <= temp_nxt;
      fine_r   <= fine_nxt;
      first_r  <= first_nxt;
      buf_r    <= buf_nxt;
      ctrl_r   <= ctrl_nxt;
      mask_r   <= mask_nxt;
      status_r <= status_nxt;
      saddr_r  <= saddr_nxt;
    end
  end

endmodule

/* rtl/video_register_scroll_interface_top.sv */
// A request accepted into the read stage moves on to the output register, which drives the out_ ports.
// Throughput: one request per cycle while the output is not stalled; the sprite memory read port sets the
// two-stage depth, and a stalled output holds one more request in the read stage.
// Reset (rst_n low, synchronous) restores the state and valid registers, then a clearing pass
// zeroes the sprite memory one byte a cycle with in_ready low.
`include "assert_macros.svh"

module video_register_scroll_interface_top
  import vrsi_pkg::*;
#(
  parameter int SPRITE_BYTES = SPRITE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_command,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_vram_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [14:0] out_vram_addr,
  output logic        out_vram_write,
  output logic        out_irq,
  output logic [2:0]  out_fine_x,
  output logic [7:0]  out_render_flags
);

  localparam int SprAw = $clog2(SPRITE_BYTES);

  res_t             res;
  spr_req_t         spr_req;
  logic [SprAw-1:0] spr_addr;
  logic             acc;

  logic [7:0] spr_mem [SPRITE_BYTES];
  logic [7:0] mem_q_r;
  logic       mem_we;
  logic [SprAw-1:0] mem_wa;
  logic [7:0] mem_wd;

  logic [SprAw:0] clr_cnt_r;
  logic           clr_done;

  logic  s1_v_r;
  logic  s1_spr_r;
  res_t  s1_res_r;
  logic  s1_adv;
  logic  out_v_r;
  res_t  out_res_r;

  assign clr_done = clr_cnt_r[SprAw];
  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = clr_done && (!s1_v_r || s1_adv);
  assign acc      = in_valid && in_ready;

  vrsi_regs #(
    .SPRITE_BYTES(SPRITE_BYTES)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (acc),
    .command   (in_command),
    .write_data(in_write_data),
    .vram_data (in_vram_data),
    .res       (res),
    .spr_req   (spr_req),
    .spr_addr  (spr_addr)
  );

  // clearing pass owns the write port until it completes
  assign mem_we = clr_done ? (acc && spr_req.wr) : 1'b1;
  assign mem_wa = clr_done ? spr_addr : clr_cnt_r[SprAw-1:0];
  assign mem_wd = clr_done ? spr_req.data : 8'h00;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      spr_mem[mem_wa] <= mem_wd;
    end
    if (acc && spr_req.rd) begin
      mem_q_r <= spr_mem[spr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
      s1_spr_r <= spr_req.rd;
    end
    if (s1_adv && s1_v_r) begin
      out_res_r <= s1_res_r;
      if (s1_spr_r) begin
        out_res_r.read_data <= mem_q_r;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_read_data    = out_res_r.read_data;
  assign out_vram_addr    = out_res_r.vram_addr;
  assign out_vram_write   = out_res_r.vram_write;
  assign out_irq          = out_res_r.irq;
  assign out_fine_x       = out_res_r.fine_x;
  assign out_render_flags = out_res_r.render_flags;

  `VRSI_NEVER(a_no_req_while_clearing, clk, rst_n, acc && !clr_done)
  `VRSI_NEVER(a_spr_rd_wr_excl, clk, rst_n, spr_req.wr && spr_req.rd)
  `VRSI_ASSERT(a_full_blocks_input, clk, rst_n, (s1_v_r && out_v_r && !out_ready) |-> !in_ready)
  `VRSI_ASSERT(a_write_reads_zero, clk, rst_n, (out_v_r && out_vram_write) |-> (out_read_data == 8'h00))
  `VRSI_ASSERT(a_acc_fills_s1, clk, rst_n, acc |=> s1_v_r)

endmodule

/* dv/video_register_scroll_interface_top_tb.sv */
module video_register_scroll_interface_top_tb
  import vrsi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT      = 400;
  localparam int PAUSE_AT     = 1000;
  localparam int BURST_FROM   = 1200;
  localparam int BURST_TO     = 1500;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIR_COUNT    = 26;

  localparam logic [4:0] CMD_UNUSED_LAST = 5'd31;

  typedef struct packed {
    logic [4:0] cmd;
    logic [7:0] wd;
    logic [7:0] vd;
    logic       typed;
    res_t       res;
  } stim_row_t;

  // Typed results hold only where the value is obvious from reset state.
  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    '{CMD_STATUS_RD,   8'h00, 8'h00, 1'b1, '{8'h00, 15'h0000, 1'b0, 1'b0, 3'd0, 8'h18}},
    '{CMD_SPR_DATA_RD, 8'h00, 8'hff, 1'b1, '{8'h00, 15'h0000, 1'b0, 1'b0, 3'd0, 8'h18}},
    '{CMD_CTRL_WR,     8'hff, 8'h00, 1'b1, '{8'h00, 15'h0000, 1'b0, 1'b0, 3'd0, 8'hf8}},
    '{CMD_MASK_WR,     8'h00, 8'h00, 1'b0, '0},
    '{CMD_VBLANK,      8'h00, 8'h00, 1'b1, '{8'h00, 15'h0000, 1'b0, 1'b1, 3'd0, 8'he6}},
    '{CMD_COARSE_X,    8'h00, 8'h00, 1'b0, '0},
    '{CMD_STATUS_RD,   8'h00, 8'h00, 1'b1, '{8'h80, 15'h0000, 1'b0, 1'b0, 3'd0, 8'he6}},
    '{CMD_MASK_WR,     8'hff, 8'h00, 1'b0, '0},
    '{CMD_SCROLL_WR,   8'hff, 8'h00, 1'b0, '0},
    '{CMD_SCROLL_WR,   8'hff, 8'h00, 1'b0, '0},
    '{CMD_COPY_HORIZ,  8'h00, 8'h00, 1'b0, '0},
    '{CMD_COPY_VERT,   8'h00, 8'h00, 1'b0, '0},
    '{CMD_DATA_WR,     8'hc3, 8'h00, 1'b0, '0},
    '{CMD_COPY_VERT,   8'h00, 8'h00, 1'b0, '0},
    '{CMD_FINE_Y,      8'h00, 8'h00, 1'b0, '0},
    '{CMD_COARSE_X,    8'h00, 8'h00, 1'b0, '0},
    '{CMD_DATA_RD,     8'h00, 8'h5a, 1'b0, '0},
    '{CMD_ADDR_WR,     8'h3f, 8'h00, 1'b0, '0},
    '{CMD_ADDR_WR,     8'h00, 8'h00, 1'b0, '0},
    '{CMD_DATA_RD,     8'h00, 8'ha5, 1'b0, '0},
    '{CMD_SPR_ADDR_WR, 8'hff, 8'h00, 1'b0, '0},
    '{CMD_SPR_DATA_WR, 8'h77, 8'h00, 1'b0, '0},
    '{CMD_SPR_ZERO,    8'h00, 8'h00, 1'b0, '0},
    '{CMD_SPR_OVF,     8'h00, 8'h00, 1'b0, '0},
    '{CMD_PRERENDER,   8'h00, 8'h00, 1'b0, '0},
    '{CMD_UNUSED_LAST, 8'hff, 8'hff, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  in_command;
  logic [7:0]  in_write_data;
  logic [7:0]  in_vram_data;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic [14:0] out_vram_addr;
  logic        out_vram_write;
  logic        out_irq;
  logic [2:0]  out_fine_x;
  logic [7:0]  out_render_flags;

  video_register_scroll_interface_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_write_data   (in_write_data),
    .in_vram_data    (in_vram_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_vram_addr   (out_vram_addr),
    .out_vram_write  (out_vram_write),
    .out_irq         (out_irq),
    .out_fine_x      (out_fine_x),
    .out_render_flags(out_render_flags)
  );

  // Predicted register state.
  logic [14:0] v_addr;
  logic [14:0] t_addr;
  logic [2:0]  fine_x_q;
  logic        first_wr;
  logic [7:0]  rd_buffer;
  logic [4:0]  ctrl_q;
  logic [4:0]  mask_q;
  logic [2:0]  status_q;
  logic [7:0]  oam_ptr;
  logic [7:0]  oam [SPRITE_BYTES_DEF];

  res_t pending_results [$];
  int   req_count;
  int   rand_count;
  int   result_count;
  int   mismatches;
  int   cycles;
  bit   hold_req;
  bit   no_idle;

  function automatic res_t scroll_regs_step(input logic [4:0] cmd, input logic [7:0] wd,
                                            input logic [7:0] vd);
    res_t        r;
    logic [14:0] v;
    logic [4:0]  row;
    r = '0;
    r.vram_addr = v_addr;
    case (cmd)
      CMD_CTRL_WR: begin
        ctrl_q = {wd[7], wd[5], wd[4], wd[3], wd[2]};
        t_addr[11:10] = wd[1:0];
      end
      CMD_MASK_WR: mask_q = {wd[4], wd[3], ~wd[2], ~wd[1], wd[0]};
      CMD_STATUS_RD: begin
        r.read_data = {status_q, 5'b0};
        status_q[2] = 1'b0;
        first_wr = 1'b1;
      end
      CMD_SPR_ADDR_WR: oam_ptr = wd;
      CMD_SPR_DATA_WR: begin
        oam[oam_ptr] = wd;
        oam_ptr = oam_ptr + 8'd1;
      end
      CMD_SPR_DATA_RD: r.read_data = oam[oam_ptr];
      CMD_SCROLL_WR: begin
        if (first_wr) begin
          t_addr[4:0] = wd[7:3];
          fine_x_q = wd[2:0];
        end else begin
          t_addr[14:12] = wd[2:0];
          t_addr[9:5] = wd[7:3];
        end
        first_wr = ~first_wr;
      end
      CMD_ADDR_WR: begin
        if (first_wr) begin
          t_addr[14:8] = {1'b0, wd[5:0]};
        end else begin
          t_addr[7:0] = wd;
          v_addr = t_addr;
        end
        first_wr = ~first_wr;
      end
      CMD_DATA_WR: begin
        r.vram_write = 1'b1;
        v_addr = v_addr + (ctrl_q[0] ? INC_DOWN : INC_ACROSS);
      end
      CMD_DATA_RD: begin
        // Palette range bypasses the read buffer.
        r.read_data = (v_addr[13:0] >= PALETTE_BASE) ? vd : rd_buffer;
        rd_buffer = vd;
        v_addr = v_addr + (ctrl_q[0] ? INC_DOWN : INC_ACROSS);
      end
      CMD_COARSE_X: begin
        if (mask_q[4:3] != 2'b00) begin
          if (v_addr[4:0] == LAST_COL) begin
            v_addr[4:0] = 5'd0;
            v_addr[10] = ~v_addr[10];
          end else begin
            v_addr = v_addr + 15'd1;
          end
        end
      end
      CMD_FINE_Y: begin
        if (mask_q[4:3] != 2'b00) begin
          v = v_addr;
          if (v[14:12] != 3'd7) begin
            v[14:12] = v[14:12] + 3'd1;
          end else begin
            v[14:12] = 3'd0;
            row = v[9:5];
            if (row == LAST_ROW) begin
              row = 5'd0;
              v[11] = ~v[11];
            end else if (row == ROW_MAX) begin
              row = 5'd0;
            end else begin
              row = row + 5'd1;
            end
            v[9:5] = row;
          end
          v_addr = v;
        end
      end
      CMD_COPY_HORIZ: begin
        if (mask_q[4:3] != 2'b00)
          v_addr = (v_addr & ~HORIZ_MASK) | (t_addr & HORIZ_MASK);
      end
      CMD_COPY_VERT: begin
        if (mask_q[4:3] != 2'b00)
          v_addr = (v_addr & ~VERT_MASK) | (t_addr & VERT_MASK);
      end
      CMD_VBLANK: begin
        status_q[2] = 1'b1;
        r.irq = ctrl_q[4];
      end
      CMD_PRERENDER: status_q = 3'b000;
      CMD_SPR_ZERO:  status_q[1] = 1'b1;
      CMD_SPR_OVF:   status_q[0] = 1'b1;
      default: ;
    endcase
    r.fine_x = fine_x_q;
    r.render_flags = {ctrl_q[1], ctrl_q[2], ctrl_q[3], mask_q};
    return r;
  endfunction

  task automatic push_request(input logic [4:0] cmd, input logic [7:0] wd,
                              input logic [7:0] vd, input logic typed, input res_t typed_res);
    res_t pred;
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_write_data <= wd;
    in_vram_data  <= vd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = scroll_regs_step(cmd, wd, vd);
    pending_results.insert(pending_results.size(), typed ? typed_res : pred);
    req_count++;
  endtask

  task automatic req(input logic [4:0] cmd, input logic [7:0] wd);
    push_request(cmd, wd, 8'($urandom), 1'b0, '0);
    rand_count++;
  endtask

  task automatic run_scenario();
    int         kind;
    int         n;
    logic [7:0] a;
    kind = $urandom_range(99);
    if (kind < 15) begin
      // scroll pair, usually after a status read to reset the toggle
      if ($urandom_range(9) < 7) req(CMD_STATUS_RD, 8'($urandom));
      req(CMD_SCROLL_WR, 8'($urandom));
      if ($urandom_range(4) == 0) req(CMD_SCROLL_WR, {5'd29, 3'($urandom)});
      else req(CMD_SCROLL_WR, 8'($urandom));
    end else if (kind < 35) begin
      if ($urandom_range(9) < 7) req(CMD_STATUS_RD, 8'($urandom));
      a = 8'($urandom);
      if ($urandom_range(3) == 0) a[5:0] = 6'h3f;
      req(CMD_ADDR_WR, a);
      req(CMD_ADDR_WR, 8'($urandom));
      n = $urandom_range(6, 1);
      repeat (n) req($urandom_range(1) ? CMD_DATA_RD : CMD_DATA_WR, 8'($urandom));
    end else if (kind < 55) begin
      n = $urandom_range(8, 1);
      repeat (n) req(CMD_COARSE_X, 8'($urandom));
      n = ($urandom_range(6) == 0) ? $urandom_range(16, 8) : 1;
      repeat (n) req(CMD_FINE_Y, 8'($urandom));
      req(CMD_COPY_HORIZ, 8'($urandom));
      if ($urandom_range(4) == 0) req(CMD_COPY_VERT, 8'($urandom));
    end else if (kind < 65) begin
      n = $urandom_range(5, 2);
      repeat (n) begin
        case ($urandom_range(4))
          0: req(CMD_VBLANK, 8'($urandom));
          1: req(CMD_STATUS_RD, 8'($urandom));
          2: req(CMD_PRERENDER, 8'($urandom));
          3: req(CMD_SPR_ZERO, 8'($urandom));
          default: req(CMD_SPR_OVF, 8'($urandom));
        endcase
      end
    end else if (kind < 78) begin
      a = 8'($urandom);
      n = $urandom_range(6, 1);
      req(CMD_SPR_ADDR_WR, a);
      repeat (n) req(CMD_SPR_DATA_WR, 8'($urandom));
      req(CMD_SPR_ADDR_WR, a);
      repeat (n) req(CMD_SPR_DATA_RD, 8'($urandom));
    end else if (kind < 88) begin
      if ($urandom_range(1)) begin
        req(CMD_CTRL_WR, 8'($urandom));
      end else begin
        // keep rendering on most of the time
        a = 8'($urandom);
        if ($urandom_range(3) != 0 && a[4:3] == 2'b00) a[3] = 1'b1;
        req(CMD_MASK_WR, a);
      end
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) req(5'($urandom_range(31)), 8'($urandom));
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("FAIL video_register_scroll_interface_top");
      $finish;
    end
  end

  // Receiver: random backpressure, plus one long hold when the sender asks.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual vram_addr %0h", $time,
                 out_vram_addr);
      end else begin
        want = pending_results.pop_front();
        result_count++;
        check_field("read_data", want.read_data, out_read_data);
        check_field("vram_addr", want.vram_addr, out_vram_addr);
        check_field("vram_write", want.vram_write, out_vram_write);
        check_field("irq", want.irq, out_irq);
        check_field("fine_x", want.fine_x, out_fine_x);
        check_field("render_flags", want.render_flags, out_render_flags);
      end
    end
  end

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    in_valid      <= 1'b0;
    in_command    <= CMD_CTRL_WR;
    in_write_data <= 8'h00;
    in_vram_data  <= 8'h00;
    v_addr    = '0;
    t_addr    = '0;
    fine_x_q  = '0;
    first_wr  = 1'b1;
    rd_buffer = '0;
    ctrl_q    = '0;
    mask_q    = MASK_RESET;
    status_q  = '0;
    oam_ptr   = '0;
    foreach (oam[i]) oam[i] = 8'h00;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    for (int i = 0; i < DIR_COUNT; i++)
      push_request(DIR_ROWS[i].cmd, DIR_ROWS[i].wd, DIR_ROWS[i].vd, DIR_ROWS[i].typed,
                   DIR_ROWS[i].res);

    while (rand_count < RANDOM_ITEMS) begin
      run_scenario();
      no_idle = (rand_count >= BURST_FROM) && (rand_count < BURST_TO);
      if (!hold_done && rand_count >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && rand_count >= PAUSE_AT) begin
        // drain everything before offering more
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
        pause_done = 1'b1;
      end
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed, %0d random), checked %0d results",
             req_count, DIR_COUNT, rand_count, result_count);
    $display("Covered all commands, unused codes, one long output hold and a full drain");
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS video_register_scroll_interface_top");
    else
      $display("FAIL video_register_scroll_interface_top");
    $finish;
  end

endmodule

/* video_register_scroll_interface_top.f */
+incdir+rtl
rtl/vrsi_pkg.sv
rtl/vrsi_regs.sv
rtl/video_register_scroll_interface_top.sv
dv/video_register_scroll_interface_top_tb.sv
